// File: hdl/rafc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rate adaptation frame classifier package
// Shared types, codes and helpers for the front, queue and back parts.
// ----------------------------------------------------------------------------
package rafc_pkg;

    // Default number of histogram buckets.
    localparam int GAP_BUCKETS_DEF = 100;

    // Window geometry.
    localparam int WIN_DEPTH = 5;
    localparam logic [2:0] WIN_FULL = 3'd5;
    localparam logic [2:0] WIN_MIDDLE_READY = 3'd3;

    // Sample gap limits and bucket helpers.
    localparam logic [12:0] GAP_LIMIT = 13'd1000;
    localparam logic [6:0] NO_BUCKET = 7'd100;
    localparam logic [9:0] SAMPLE_GAP_INIT = 10'd1023;
    // Division by ten as (x * 205) >> 11, exact below 1029.
    localparam logic [17:0] RECIP_TEN = 18'd205;

    // Queue depth between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Event codes.
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_STEADY  = 3'd1;
    localparam logic [2:0] EV_SAMPLE  = 3'd2;
    localparam logic [2:0] EV_CHANGE  = 3'd3;
    localparam logic [2:0] EV_SPECIAL = 3'd4;

    // Change kind codes.
    localparam logic [1:0] CK_SEQ        = 2'd0;
    localparam logic [1:0] CK_SEQ_AFTER  = 2'd1;
    localparam logic [1:0] CK_SEQ_BEFORE = 2'd2;
    localparam logic [1:0] CK_NON_SEQ    = 2'd3;

    // One classified frame handed from front to back.
    typedef struct packed {
        logic [2:0]  ev;
        logic [1:0]  ck;
        logic [11:0] mseq;
        logic [7:0]  mrate;
        logic [3:0]  mretries;
        logic [31:0] msecond;
        logic [31:0] frames;
    } rec_t;

    // Back part sequencer states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_LOAD,
        ST_UPDATE
    } back_state_t;

    // Saturating increment of a 32-bit counter.
    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        logic [31:0] r;
        r = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
        return r;
    endfunction

endpackage

// File: hdl/rafc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rafc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 100,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/rafc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Classifier front part
// Holds the five-frame window and the best rate and classifies the middle frame.
// ----------------------------------------------------------------------------
module rafc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              is_null_frame,
    input  logic [7:0]        frame_rate,
    input  logic [11:0]       frame_seqno,
    input  logic [3:0]        frame_retries,
    input  logic [31:0]       data_frames_seen,
    input  logic [31:0]       arrival_second,
    output rafc_pkg::rec_t    rec
);

    logic [7:0]  rate_reg   [rafc_pkg::WIN_DEPTH];
    logic [11:0] seqno_reg  [rafc_pkg::WIN_DEPTH];
    logic [3:0]  retry_reg  [rafc_pkg::WIN_DEPTH];
    logic [31:0] second_reg [rafc_pkg::WIN_DEPTH];
    logic [2:0]  fill_reg, fill_next;
    logic [7:0]  best_reg, best_next;
    logic        after_seq, before_seq;

    // Window fill count after this frame.
    always_comb
    begin
        fill_next = fill_reg;
        if (fill_reg != rafc_pkg::WIN_FULL)
        begin
            fill_next = fill_reg + 3'd1;
        end
    end

    // Sequence tests, no wrap at the top of the seqno range.
    assign after_seq  = ({1'b0, seqno_reg[0]} == {1'b0, seqno_reg[1]} + 13'd1);
    assign before_seq = ({1'b0, seqno_reg[1]} == {1'b0, seqno_reg[2]} + 13'd1);

    // Classify the frame that becomes the middle one (today's slot 1).
    always_comb
    begin
        rec          = '0;
        rec.frames   = data_frames_seen;
        rec.mretries = retry_reg[1];
        rec.msecond  = second_reg[1];
        best_next    = best_reg;
        if (!is_null_frame)
        begin
            if (fill_next != rafc_pkg::WIN_FULL)
            begin
                if (fill_next >= rafc_pkg::WIN_MIDDLE_READY)
                begin
                    best_next = rate_reg[1];
                end
            end
            else
            begin
                rec.mseq  = seqno_reg[1];
                rec.mrate = rate_reg[1];
                if (rate_reg[1] == best_reg)
                begin
                    rec.ev = rafc_pkg::EV_STEADY;
                end
                else if (rate_reg[2] == rate_reg[0])
                begin
                    rec.ev = rafc_pkg::EV_SAMPLE;
                end
                else if (rate_reg[1] == rate_reg[0])
                begin
                    rec.ev    = rafc_pkg::EV_CHANGE;
                    best_next = rate_reg[1];
                    if (after_seq && before_seq)
                    begin
                        rec.ck = rafc_pkg::CK_SEQ;
                    end
                    else if (after_seq)
                    begin
                        rec.ck = rafc_pkg::CK_SEQ_AFTER;
                    end
                    else if (before_seq)
                    begin
                        rec.ck = rafc_pkg::CK_SEQ_BEFORE;
                    end
                    else
                    begin
                        rec.ck = rafc_pkg::CK_NON_SEQ;
                    end
                end
                else
                begin
                    rec.ev = rafc_pkg::EV_SPECIAL;
                end
            end
        end
    end

    // Control state: fill count and best rate.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            best_reg <= '0;
        end
        else if (accept && !is_null_frame)
        begin
            fill_reg <= fill_next;
            best_reg <= best_next;
        end
    end

    // Window shift line; cleared at reset since it feeds classification.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rafc_pkg::WIN_DEPTH; i++)
            begin
                rate_reg[i]   <= '0;
                seqno_reg[i]  <= '0;
                retry_reg[i]  <= '0;
                second_reg[i] <= '0;
            end
        end
        else if (accept && !is_null_frame)
        begin
            for (int i = rafc_pkg::WIN_DEPTH - 1; i > 0; i--)
            begin
                rate_reg[i]   <= rate_reg[i-1];
                seqno_reg[i]  <= seqno_reg[i-1];
                retry_reg[i]  <= retry_reg[i-1];
                second_reg[i] <= second_reg[i-1];
            end
            rate_reg[0]   <= frame_rate;
            seqno_reg[0]  <= frame_seqno;
            retry_reg[0]  <= frame_retries;
            second_reg[0] <= arrival_second;
        end
    end

endmodule

// File: hdl/rafc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Classifier queue
// Short first-in first-out buffer of classified frames between front and back.
// ----------------------------------------------------------------------------
module rafc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rafc_pkg::rec_t push_rec,
    input  logic           pop,
    output rafc_pkg::rec_t head_rec,
    output logic           empty,
    output logic           full,
    output logic [$clog2(rafc_pkg::QUEUE_DEPTH+1)-1:0] level
);

    localparam int PW = $clog2(rafc_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(rafc_pkg::QUEUE_DEPTH + 1);

    rafc_pkg::rec_t entry_reg [rafc_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(rafc_pkg::QUEUE_DEPTH));
    assign head_rec = entry_reg[rd_ptr_reg];
    assign level    = count_reg;

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(rafc_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(rafc_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

// File: hdl/rafc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Classifier back part
// Keeps the statistics and the sample gap histogram and drives the results.
// ----------------------------------------------------------------------------
module rafc_back #(
    parameter int GAP_BUCKETS = rafc_pkg::GAP_BUCKETS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  rafc_pkg::rec_t q_rec,
    output logic           q_pop,
    output logic           clearing,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [2:0]     event_kind,
    output logic [1:0]     change_kind,
    output logic [11:0]    middle_seqno,
    output logic [7:0]     middle_rate,
    output logic [3:0]     max_retry_seen,
    output logic [31:0]    rate_change_total,
    output logic [31:0]    sample_total,
    output logic [31:0]    min_frames_between_changes,
    output logic [31:0]    max_changes_per_second,
    output logic [6:0]     gap_bucket,
    output logic [31:0]    gap_bucket_count,
    output logic [9:0]     min_sample_gap
);

    localparam int AW = (GAP_BUCKETS > 1) ? $clog2(GAP_BUCKETS) : 1;

    rafc_pkg::back_state_t state_reg, state_next;

    // Sequencer outputs.
    logic          ram_we, ram_re, do_update, load_work;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata, ram_rdata;

    // Item under work and its gap terms.
    rafc_pkg::rec_t work_reg;
    logic           gap_ok_reg, bump_reg;
    logic [9:0]     gap_reg;
    logic [6:0]     bucket_reg;

    // Gap terms computed while loading.
    logic [12:0]    diff;
    logic [17:0]    prod;
    logic [6:0]     bucket;
    logic           gap_ok, bump;

    // Statistics.
    logic [3:0]  retry_peak_reg, retry_peak_next;
    logic [31:0] change_cnt_reg, change_cnt_next;
    logic [31:0] sample_cnt_reg, sample_cnt_next;
    logic        lc_valid_reg, lc_valid_next;
    logic [31:0] lc_second_reg, lc_second_next;
    logic [31:0] lc_frames_reg, lc_frames_next;
    logic [31:0] cis_reg, cis_next;
    logic [31:0] least_cg_reg, least_cg_next;
    logic [31:0] peak_cps_reg, peak_cps_next;
    logic        ls_valid_reg, ls_valid_next;
    logic [11:0] ls_seqno_reg, ls_seqno_next;
    logic [9:0]  least_sg_reg, least_sg_next;
    logic [31:0] bump_count, cis_base, change_gap;

    // Output register.
    logic        out_valid_reg;
    logic [2:0]  ev_out_reg;
    logic [1:0]  ck_out_reg;
    logic [11:0] mseq_out_reg;
    logic [7:0]  mrate_out_reg;
    logic [6:0]  bucket_out_reg;
    logic [31:0] bcount_out_reg;
    logic        out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // Distance to the previous sample and its bucket.
    always_comb
    begin
        diff   = {1'b0, q_rec.mseq} - {1'b0, ls_seqno_reg};
        prod   = 18'(diff[9:0]) * rafc_pkg::RECIP_TEN;
        bucket = prod[17:11];
        gap_ok = (q_rec.ev == rafc_pkg::EV_SAMPLE) && ls_valid_reg &&
                 !diff[12] && (diff < rafc_pkg::GAP_LIMIT);
        bump   = gap_ok && (GAP_BUCKETS > 32'(bucket));
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rafc_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == AW'(GAP_BUCKETS - 1))
                begin
                    state_next = rafc_pkg::ST_LOAD;
                end
            end
            rafc_pkg::ST_LOAD:
            begin
                if (!q_empty)
                begin
                    state_next = rafc_pkg::ST_UPDATE;
                end
            end
            rafc_pkg::ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = rafc_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = rafc_pkg::ST_CLEAR;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = AW'(bucket_reg);
        ram_wdata = bump_count;
        q_pop     = 1'b0;
        load_work = 1'b0;
        do_update = 1'b0;
        clearing  = 1'b0;
        case (state_reg)
            rafc_pkg::ST_CLEAR:
            begin
                clearing  = 1'b1;
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            rafc_pkg::ST_LOAD:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    load_work = 1'b1;
                    ram_re    = 1'b1;
                end
            end
            rafc_pkg::ST_UPDATE:
            begin
                if (out_free)
                begin
                    do_update = 1'b1;
                    ram_we    = bump_reg;
                end
            end
            default:
            begin
                clearing = 1'b1;
            end
        endcase
    end

    rafc_ram #(
        .WIDTH (32),
        .DEPTH (GAP_BUCKETS),
        .AW    (AW)
    ) u_hist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (AW'(bucket)),
        .rdata (ram_rdata)
    );

    // Statistics update for the item under work.
    always_comb
    begin
        retry_peak_next = retry_peak_reg;
        change_cnt_next = change_cnt_reg;
        sample_cnt_next = sample_cnt_reg;
        lc_valid_next   = lc_valid_reg;
        lc_second_next  = lc_second_reg;
        lc_frames_next  = lc_frames_reg;
        cis_next        = cis_reg;
        least_cg_next   = least_cg_reg;
        peak_cps_next   = peak_cps_reg;
        ls_valid_next   = ls_valid_reg;
        ls_seqno_next   = ls_seqno_reg;
        least_sg_next   = least_sg_reg;
        bump_count      = rafc_pkg::sat_inc(ram_rdata);
        cis_base        = cis_reg;
        change_gap      = work_reg.frames - lc_frames_reg;

        if (work_reg.ev != rafc_pkg::EV_NONE && work_reg.mretries != 4'd0 &&
            work_reg.mretries > retry_peak_reg)
        begin
            retry_peak_next = work_reg.mretries;
        end

        if (work_reg.ev == rafc_pkg::EV_SAMPLE)
        begin
            sample_cnt_next = rafc_pkg::sat_inc(sample_cnt_reg);
            if (gap_ok_reg && gap_reg < least_sg_reg)
            begin
                least_sg_next = gap_reg;
            end
            ls_valid_next = 1'b1;
            ls_seqno_next = work_reg.mseq;
        end

        if (work_reg.ev == rafc_pkg::EV_CHANGE)
        begin
            change_cnt_next = rafc_pkg::sat_inc(change_cnt_reg);
            if (lc_valid_reg)
            begin
                if (work_reg.msecond != lc_second_reg)
                begin
                    if (cis_reg > peak_cps_reg)
                    begin
                        peak_cps_next = cis_reg;
                    end
                    cis_base = '0;
                end
                cis_next = rafc_pkg::sat_inc(cis_base);
                if (change_gap < least_cg_reg)
                begin
                    least_cg_next = change_gap;
                end
            end
            lc_valid_next  = 1'b1;
            lc_second_next = work_reg.msecond;
            lc_frames_next = work_reg.frames;
        end
    end

    // Control state, statistics and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rafc_pkg::ST_CLEAR;
            clr_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
            retry_peak_reg <= '0;
            change_cnt_reg <= '0;
            sample_cnt_reg <= '0;
            lc_valid_reg   <= 1'b0;
            lc_second_reg  <= '0;
            lc_frames_reg  <= '0;
            cis_reg        <= '0;
            least_cg_reg   <= '1;
            peak_cps_reg   <= '0;
            ls_valid_reg   <= 1'b0;
            ls_seqno_reg   <= '0;
            least_sg_reg   <= rafc_pkg::SAMPLE_GAP_INIT;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (do_update)
            begin
                out_valid_reg  <= 1'b1;
                retry_peak_reg <= retry_peak_next;
                change_cnt_reg <= change_cnt_next;
                sample_cnt_reg <= sample_cnt_next;
                lc_valid_reg   <= lc_valid_next;
                lc_second_reg  <= lc_second_next;
                lc_frames_reg  <= lc_frames_next;
                cis_reg        <= cis_next;
                least_cg_reg   <= least_cg_next;
                peak_cps_reg   <= peak_cps_next;
                ls_valid_reg   <= ls_valid_next;
                ls_seqno_reg   <= ls_seqno_next;
                least_sg_reg   <= least_sg_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item under work and result payload.
    always_ff @(posedge clk)
    begin
        if (load_work)
        begin
            work_reg   <= q_rec;
            gap_ok_reg <= gap_ok;
            bump_reg   <= bump;
            gap_reg    <= diff[9:0];
            bucket_reg <= bucket;
        end
        if (do_update)
        begin
            ev_out_reg     <= work_reg.ev;
            ck_out_reg     <= work_reg.ck;
            mseq_out_reg   <= work_reg.mseq;
            mrate_out_reg  <= work_reg.mrate;
            bucket_out_reg <= bump_reg ? bucket_reg : rafc_pkg::NO_BUCKET;
            bcount_out_reg <= bump_reg ? bump_count : 32'd0;
        end
    end

    assign out_valid                  = out_valid_reg;
    assign event_kind                 = ev_out_reg;
    assign change_kind                = ck_out_reg;
    assign middle_seqno               = mseq_out_reg;
    assign middle_rate                = mrate_out_reg;
    assign max_retry_seen             = retry_peak_reg;
    assign rate_change_total          = change_cnt_reg;
    assign sample_total               = sample_cnt_reg;
    assign min_frames_between_changes = least_cg_reg;
    assign max_changes_per_second     = peak_cps_reg;
    assign gap_bucket                 = bucket_out_reg;
    assign gap_bucket_count           = bcount_out_reg;
    assign min_sample_gap             = least_sg_reg;

endmodule

// File: hdl/rate_adaptation_frame_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rate adaptation frame classifier
// Classifies received frames in a five-frame window and keeps rate statistics.
// ----------------------------------------------------------------------------
// The block takes one frame a cycle, while in_stall is low, into a two-entry
// queue and returns one result a request. The back part takes a new frame only
// after it is through with the last one, as it does a read-modify-write of the
// sample gap histogram RAM for each frame (read in ST_LOAD, write in ST_UPDATE).
// With the queue empty and the back part idle, a request passes the queue entry
// and the work register into the output register that drives out_valid.
// After reset the block clears every histogram bucket and holds in_stall high
// during that pass. Statistic outputs are valid with each result and reflect all requests up to and including that one.
module rate_adaptation_frame_classifier_unit #(
    parameter int GAP_BUCKETS = rafc_pkg::GAP_BUCKETS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        is_null_frame,
    input  logic [7:0]  frame_rate,
    input  logic [11:0] frame_seqno,
    input  logic [3:0]  frame_retries,
    input  logic [31:0] data_frames_seen,
    input  logic [31:0] arrival_second,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_kind,
    output logic [1:0]  change_kind,
    output logic [11:0] middle_seqno,
    output logic [7:0]  middle_rate,
    output logic [3:0]  max_retry_seen,
    output logic [31:0] rate_change_total,
    output logic [31:0] sample_total,
    output logic [31:0] min_frames_between_changes,
    output logic [31:0] max_changes_per_second,
    output logic [6:0]  gap_bucket,
    output logic [31:0] gap_bucket_count,
    output logic [9:0]  min_sample_gap
);

    rafc_pkg::rec_t front_rec, head_rec;
    logic           accept, q_empty, q_full, q_pop, clearing;
    logic [$clog2(rafc_pkg::QUEUE_DEPTH+1)-1:0] q_level;

    // Stall while the queue is full or the histogram is being cleared.
    assign in_stall = q_full || clearing;
    assign accept   = in_valid && !in_stall;

    rafc_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .is_null_frame    (is_null_frame),
        .frame_rate       (frame_rate),
        .frame_seqno      (frame_seqno),
        .frame_retries    (frame_retries),
        .data_frames_seen (data_frames_seen),
        .arrival_second   (arrival_second),
        .rec              (front_rec)
    );

    rafc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .push_rec (front_rec),
        .pop      (q_pop),
        .head_rec (head_rec),
        .empty    (q_empty),
        .full     (q_full),
        .level    (q_level)
    );

    rafc_back #(
        .GAP_BUCKETS (GAP_BUCKETS)
    ) u_back (
        .clk                        (clk),
        .rst_n                      (rst_n),
        .q_empty                    (q_empty),
        .q_rec                      (head_rec),
        .q_pop                      (q_pop),
        .clearing                   (clearing),
        .out_valid                  (out_valid),
        .out_stall                  (out_stall),
        .event_kind                 (event_kind),
        .change_kind                (change_kind),
        .middle_seqno               (middle_seqno),
        .middle_rate                (middle_rate),
        .max_retry_seen             (max_retry_seen),
        .rate_change_total          (rate_change_total),
        .sample_total               (sample_total),
        .min_frames_between_changes (min_frames_between_changes),
        .max_changes_per_second     (max_changes_per_second),
        .gap_bucket                 (gap_bucket),
        .gap_bucket_count           (gap_bucket_count),
        .min_sample_gap             (min_sample_gap)
    );

    // The queue never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= 2'(rafc_pkg::QUEUE_DEPTH))
        else $error("queue overfilled");

    // Change kind is only set on rate change results.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != rafc_pkg::EV_CHANGE |-> change_kind == rafc_pkg::CK_SEQ)
        else $error("change kind on a non-change result");

    // A result without a bumped bucket carries a zero count.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && gap_bucket == rafc_pkg::NO_BUCKET |-> gap_bucket_count == 32'd0)
        else $error("bucket count without a bucket");

    // Only samples bump the histogram.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && gap_bucket != rafc_pkg::NO_BUCKET |-> event_kind == rafc_pkg::EV_SAMPLE)
        else $error("bucket bumped by a non-sample result");

    // Nothing is popped while the histogram is being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !q_pop && q_empty)
        else $error("queue activity during clearing");

endmodule

// File: tb/sv/rate_adaptation_frame_classifier_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rate adaptation frame classifier testbench
// Drives frames through the classifier with bursty requests and a stalling
// receiver, and checks every result against a behavioral predictor.
// ----------------------------------------------------------------------------
module rate_adaptation_frame_classifier_unit_test;

    localparam int NUM_BUCKETS = 100;
    localparam int RANDOM_FRAMES = 1950;
    localparam int DIRECTED_ROWS = 12;

    // One frame request.
    typedef struct {
        logic        null_frame;
        logic [7:0]  rate;
        logic [11:0] seqno;
        logic [3:0]  retries;
        logic [31:0] frames;
        logic [31:0] second;
    } frame_t;

    // One classification result.
    typedef struct {
        logic [2:0]  ev;
        logic [1:0]  ck;
        logic [11:0] mseq;
        logic [7:0]  mrate;
        logic [3:0]  retry_peak;
        logic [31:0] changes;
        logic [31:0] samples;
        logic [31:0] least_change_gap;
        logic [31:0] peak_per_second;
        logic [6:0]  bucket;
        logic [31:0] bucket_count;
        logic [9:0]  least_sample_gap;
    } verdict_t;

    // Directed row: frame plus an optional typed-in event code.
    typedef struct {
        frame_t     frm;
        logic       known;
        logic [2:0] known_ev;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        is_null_frame;
    logic [7:0]  frame_rate;
    logic [11:0] frame_seqno;
    logic [3:0]  frame_retries;
    logic [31:0] data_frames_seen;
    logic [31:0] arrival_second;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  event_kind;
    logic [1:0]  change_kind;
    logic [11:0] middle_seqno;
    logic [7:0]  middle_rate;
    logic [3:0]  max_retry_seen;
    logic [31:0] rate_change_total;
    logic [31:0] sample_total;
    logic [31:0] min_frames_between_changes;
    logic [31:0] max_changes_per_second;
    logic [6:0]  gap_bucket;
    logic [31:0] gap_bucket_count;
    logic [9:0]  min_sample_gap;

    rate_adaptation_frame_classifier_unit #(
        .GAP_BUCKETS(NUM_BUCKETS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .is_null_frame(is_null_frame),
        .frame_rate(frame_rate),
        .frame_seqno(frame_seqno),
        .frame_retries(frame_retries),
        .data_frames_seen(data_frames_seen),
        .arrival_second(arrival_second),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .event_kind(event_kind),
        .change_kind(change_kind),
        .middle_seqno(middle_seqno),
        .middle_rate(middle_rate),
        .max_retry_seen(max_retry_seen),
        .rate_change_total(rate_change_total),
        .sample_total(sample_total),
        .min_frames_between_changes(min_frames_between_changes),
        .max_changes_per_second(max_changes_per_second),
        .gap_bucket(gap_bucket),
        .gap_bucket_count(gap_bucket_count),
        .min_sample_gap(min_sample_gap)
    );

    // Predictor state.
    logic [7:0]  win_rate [5];
    logic [11:0] win_seqno [5];
    logic [3:0]  win_retries [5];
    logic [31:0] win_second [5];
    int          win_fill;
    logic [7:0]  best_rate;
    logic [3:0]  retry_peak;
    logic [31:0] change_count;
    logic [31:0] sample_count;
    logic        change_seen;
    logic [31:0] change_second;
    logic [31:0] change_frames;
    logic [31:0] changes_this_second;
    logic [31:0] least_change_gap;
    logic [31:0] peak_per_second;
    logic        sample_seen;
    logic [11:0] sample_seqno;
    logic [31:0] gap_hist [NUM_BUCKETS];
    logic [9:0]  least_sample_gap;

    verdict_t expected_results[$];
    logic     known_events[$];
    logic [2:0] known_codes[$];
    int       error_count;
    int       result_count;
    int       ev_tally [5];
    logic     stimulus_done;
    row_t     rows [DIRECTED_ROWS];

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    task automatic clear_classifier_state();
        for (int i = 0; i < 5; i++)
        begin
            win_rate[i] = '0;
            win_seqno[i] = '0;
            win_retries[i] = '0;
            win_second[i] = '0;
        end
        win_fill = 0;
        best_rate = '0;
        retry_peak = '0;
        change_count = '0;
        sample_count = '0;
        change_seen = 1'b0;
        change_second = '0;
        change_frames = '0;
        changes_this_second = '0;
        least_change_gap = '1;
        peak_per_second = '0;
        sample_seen = 1'b0;
        sample_seqno = '0;
        for (int i = 0; i < NUM_BUCKETS; i++)
            gap_hist[i] = '0;
        least_sample_gap = rafc_pkg::SAMPLE_GAP_INIT;
    endtask

    // Advance the window with one frame and classify the middle entry.
    function automatic verdict_t classify_frame(input frame_t f);
        verdict_t v;
        int diff;
        int b;
        logic after_ok;
        logic before_ok;
        logic [31:0] change_dist;
        v.ev = rafc_pkg::EV_NONE;
        v.ck = rafc_pkg::CK_SEQ;
        v.mseq = '0;
        v.mrate = '0;
        v.bucket = rafc_pkg::NO_BUCKET;
        v.bucket_count = '0;
        if (!f.null_frame)
        begin
            for (int i = 4; i > 0; i--)
            begin
                win_rate[i] = win_rate[i-1];
                win_seqno[i] = win_seqno[i-1];
                win_retries[i] = win_retries[i-1];
                win_second[i] = win_second[i-1];
            end
            win_rate[0] = f.rate;
            win_seqno[0] = f.seqno;
            win_retries[0] = f.retries;
            win_second[0] = f.second;
            if (win_fill < 5)
                win_fill++;
            if (win_fill < 5)
            begin
                if (win_fill >= 3)
                    best_rate = win_rate[2];
            end
            else
            begin
                v.mseq = win_seqno[2];
                v.mrate = win_rate[2];
                if (win_retries[2] > retry_peak)
                    retry_peak = win_retries[2];
                if (v.mrate == best_rate)
                    v.ev = rafc_pkg::EV_STEADY;
                else if (win_rate[3] == win_rate[1])
                begin
                    v.ev = rafc_pkg::EV_SAMPLE;
                    sample_count = bump(sample_count);
                    if (sample_seen)
                    begin
                        diff = int'(v.mseq) - int'(sample_seqno);
                        if (diff >= 0 && diff < 1000)
                        begin
                            b = diff / 10;
                            if (b < NUM_BUCKETS)
                            begin
                                gap_hist[b] = bump(gap_hist[b]);
                                v.bucket = 7'(b);
                                v.bucket_count = gap_hist[b];
                            end
                            if (diff < int'(least_sample_gap))
                                least_sample_gap = 10'(diff);
                        end
                    end
                    sample_seen = 1'b1;
                    sample_seqno = v.mseq;
                end
                else if (v.mrate == win_rate[1])
                begin
                    v.ev = rafc_pkg::EV_CHANGE;
                    after_ok = (int'(win_seqno[1]) == int'(v.mseq) + 1);
                    before_ok = (int'(v.mseq) == int'(win_seqno[3]) + 1);
                    if (after_ok && before_ok)
                        v.ck = rafc_pkg::CK_SEQ;
                    else if (after_ok)
                        v.ck = rafc_pkg::CK_SEQ_AFTER;
                    else if (before_ok)
                        v.ck = rafc_pkg::CK_SEQ_BEFORE;
                    else
                        v.ck = rafc_pkg::CK_NON_SEQ;
                    change_count = bump(change_count);
                    best_rate = v.mrate;
                    if (change_seen)
                    begin
                        if (win_second[2] != change_second)
                        begin
                            if (changes_this_second > peak_per_second)
                                peak_per_second = changes_this_second;
                            changes_this_second = '0;
                        end
                        changes_this_second = bump(changes_this_second);
                        change_dist = f.frames - change_frames;
                        if (change_dist < least_change_gap)
                            least_change_gap = change_dist;
                    end
                    change_seen = 1'b1;
                    change_second = win_second[2];
                    change_frames = f.frames;
                end
                else
                    v.ev = rafc_pkg::EV_SPECIAL;
            end
        end
        v.retry_peak = retry_peak;
        v.changes = change_count;
        v.samples = sample_count;
        v.least_change_gap = least_change_gap;
        v.peak_per_second = peak_per_second;
        v.least_sample_gap = least_sample_gap;
        return v;
    endfunction

    // Clock generation.
    initial
        clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver stall pattern: alternating calm and choppy stretches.
    int stall_phase;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if ((stall_phase / 200) % 3 == 0)
                out_stall <= 1'b0;
            else if ((stall_phase / 200) % 3 == 1)
                out_stall <= ($urandom_range(0, 3) == 0);
            else
                out_stall <= ($urandom_range(0, 1) == 0);
        end
    end

    // Result checking.
    always @(posedge clk)
    begin
        verdict_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result event_kind %0d", event_kind);
                error_count++;
            end
            else
            begin
                e = expected_results.pop_front();
                result_count++;
                if (e.ev <= rafc_pkg::EV_SPECIAL)
                    ev_tally[e.ev]++;
                if (known_events.pop_front() && known_codes[0] != event_kind)
                begin
                    $error("event_kind table: expected %0d actual %0d",
                           known_codes[0], event_kind);
                    error_count++;
                end
                void'(known_codes.pop_front());
                if (e.ev !== event_kind)
                begin
                    $error("event_kind: expected %0d actual %0d", e.ev, event_kind);
                    error_count++;
                end
                if (e.ck !== change_kind)
                begin
                    $error("change_kind: expected %0d actual %0d", e.ck, change_kind);
                    error_count++;
                end
                if (e.mseq !== middle_seqno)
                begin
                    $error("middle_seqno: expected %0d actual %0d", e.mseq, middle_seqno);
                    error_count++;
                end
                if (e.mrate !== middle_rate)
                begin
                    $error("middle_rate: expected %0d actual %0d", e.mrate, middle_rate);
                    error_count++;
                end
                if (e.retry_peak !== max_retry_seen)
                begin
                    $error("max_retry_seen: expected %0d actual %0d",
                           e.retry_peak, max_retry_seen);
                    error_count++;
                end
                if (e.changes !== rate_change_total)
                begin
                    $error("rate_change_total: expected %0d actual %0d",
                           e.changes, rate_change_total);
                    error_count++;
                end
                if (e.samples !== sample_total)
                begin
                    $error("sample_total: expected %0d actual %0d", e.samples, sample_total);
                    error_count++;
                end
                if (e.least_change_gap !== min_frames_between_changes)
                begin
                    $error("min_frames_between_changes: expected %0d actual %0d",
                           e.least_change_gap, min_frames_between_changes);
                    error_count++;
                end
                if (e.peak_per_second !== max_changes_per_second)
                begin
                    $error("max_changes_per_second: expected %0d actual %0d",
                           e.peak_per_second, max_changes_per_second);
                    error_count++;
                end
                if (e.bucket !== gap_bucket)
                begin
                    $error("gap_bucket: expected %0d actual %0d", e.bucket, gap_bucket);
                    error_count++;
                end
                if (e.bucket_count !== gap_bucket_count)
                begin
                    $error("gap_bucket_count: expected %0d actual %0d",
                           e.bucket_count, gap_bucket_count);
                    error_count++;
                end
                if (e.least_sample_gap !== min_sample_gap)
                begin
                    $error("min_sample_gap: expected %0d actual %0d",
                           e.least_sample_gap, min_sample_gap);
                    error_count++;
                end
            end
        end
    end

    // Present one frame and hold it until the block takes it.
    task automatic send_frame(input frame_t f, input logic known, input logic [2:0] code);
        in_valid <= 1'b1;
        is_null_frame <= f.null_frame;
        frame_rate <= f.rate;
        frame_seqno <= f.seqno;
        frame_retries <= f.retries;
        data_frames_seen <= f.frames;
        arrival_second <= f.second;
        expected_results.push_back(classify_frame(f));
        known_events.push_back(known);
        known_codes.push_back(code);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic idle_sender(input int gap);
        in_valid <= 1'b0;
        repeat (gap)
            @(posedge clk);
    endtask

    function automatic frame_t make_frame(input logic [7:0] rate, input logic [11:0] seqno,
                                          input logic [3:0] retries, input logic [31:0] frames,
                                          input logic [31:0] second, input logic null_frame);
        frame_t f;
        f.null_frame = null_frame;
        f.rate = rate;
        f.seqno = seqno;
        f.retries = retries;
        f.frames = frames;
        f.second = second;
        return f;
    endfunction

    // Stimulus.
    initial
    begin
        frame_t f;
        logic [7:0] base_rate;
        logic [7:0] probe_rate;
        logic [11:0] seq;
        logic [31:0] frames;
        logic [31:0] second;
        int burst;
        int sent;
        int kind;
        rst_n = 1'b0;
        in_valid = 1'b0;
        is_null_frame = 1'b0;
        frame_rate = '0;
        frame_seqno = '0;
        frame_retries = '0;
        data_frames_seen = '0;
        arrival_second = '0;
        stimulus_done = 1'b0;
        error_count = 0;
        result_count = 0;
        for (int i = 0; i < 5; i++)
            ev_tally[i] = 0;
        clear_classifier_state();
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: null after reset, warmup, steady, sample, change, special,
        // with extremes of each field.
        rows[0] = '{make_frame(8'd255, 12'd4095, 4'd15, '1, '1, 1'b1), 1'b1,
                    rafc_pkg::EV_NONE};
        rows[1] = '{make_frame(8'd10, 12'd0, 4'd0, 32'd0, 32'd0, 1'b0), 1'b1,
                    rafc_pkg::EV_NONE};
        rows[2] = '{make_frame(8'd10, 12'd1, 4'd15, 32'd1, 32'd0, 1'b0), 1'b1,
                    rafc_pkg::EV_NONE};
        rows[3] = '{make_frame(8'd10, 12'd2, 4'd0, 32'd2, 32'd0, 1'b0), 1'b1,
                    rafc_pkg::EV_NONE};
        rows[4] = '{make_frame(8'd20, 12'd3, 4'd3, 32'd3, 32'd0, 1'b0), 1'b1,
                    rafc_pkg::EV_NONE};
        rows[5] = '{make_frame(8'd10, 12'd4, 4'd0, 32'd4, 32'd0, 1'b0), 1'b1,
                    rafc_pkg::EV_STEADY};
        rows[6] = '{make_frame(8'd0, 12'd5, 4'd0, 32'd5, 32'd1, 1'b0), 1'b1,
                    rafc_pkg::EV_SAMPLE};
        rows[7] = '{make_frame(8'd0, 12'd6, 4'd0, 32'd6, 32'd1, 1'b0), 1'b0,
                    rafc_pkg::EV_NONE};
        rows[8] = '{make_frame(8'd255, 12'd4095, 4'd0, '1, '1, 1'b0), 1'b0,
                    rafc_pkg::EV_NONE};
        rows[9] = '{make_frame(8'd1, 12'd7, 4'd0, 32'd7, 32'd2, 1'b0), 1'b0,
                    rafc_pkg::EV_NONE};
        rows[10] = '{make_frame(8'd1, 12'd8, 4'd0, 32'd8, 32'd2, 1'b0), 1'b0,
                     rafc_pkg::EV_NONE};
        rows[11] = '{make_frame(8'd1, 12'd9, 4'd0, 32'd9, 32'd2, 1'b1), 1'b1,
                     rafc_pkg::EV_NONE};
        foreach (rows[i])
            send_frame(rows[i].frm, rows[i].known, rows[i].known_ev);

        // Random part: mostly well-formed rate patterns with probes and changes.
        base_rate = 8'($urandom_range(0, 255));
        seq = 12'($urandom_range(0, 4095));
        frames = $urandom();
        second = $urandom();
        sent = 0;
        while (sent < RANDOM_FRAMES)
        begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < RANDOM_FRAMES; k++)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 8)
                    probe_rate = 8'($urandom_range(0, 255));
                else
                    probe_rate = base_rate;
                if (kind >= 8 && kind < 20)
                begin
                    // Single probe frame at another rate.
                    probe_rate = base_rate ^ 8'($urandom_range(1, 255));
                end
                else if (kind >= 20 && kind < 28)
                begin
                    // Rate change that sticks.
                    base_rate = 8'($urandom_range(0, 255));
                    probe_rate = base_rate;
                end
                if ($urandom_range(0, 9) != 0)
                    seq = seq + 12'($urandom_range(0, 3));
                else
                    seq = 12'($urandom_range(0, 4095));
                frames = frames + $urandom_range(0, 20);
                if ($urandom_range(0, 49) == 0)
                    frames = $urandom();
                if ($urandom_range(0, 5) == 0)
                    second = second + $urandom_range(1, 2);
                f = make_frame(probe_rate, seq, 4'($urandom_range(0, 15)), frames,
                               second, ($urandom_range(0, 19) == 0));
                send_frame(f, 1'b0, rafc_pkg::EV_NONE);
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                idle_sender($urandom_range(1, 12));
        end
        in_valid <= 1'b0;
        stimulus_done <= 1'b1;
    end

    // End of run: drain, settle, report.
    initial
    begin
        wait (stimulus_done === 1'b1);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
        $display("Checked %0d results: %0d none, %0d steady, %0d sample, %0d change, %0d special.",
                 result_count, ev_tally[0], ev_tally[1], ev_tally[2], ev_tally[3], ev_tally[4]);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
